### rtl/sps_pkg.sv
// Shared types, constants and coil tables for the stepper phase sequencer.
package sps_pkg;

    localparam int DELAY_W = 16;
    localparam int DEG_W   = 16;
    localparam int COIL_W  = 4;
    localparam int PHASE_W = 3;
    localparam int SEQ_W   = 17;
    localparam int IDX_W   = 1;

    localparam logic [IDX_W-1:0] REG_STEP_DELAY = 1'd0;
    localparam logic [IDX_W-1:0] REG_HALF_STEP  = 1'd1;

    localparam logic [DELAY_W-1:0] STEP_DELAY_RST = 16'd2;

    // Degrees are scaled by 64 and divided by 45 through a fixed-point reciprocal.
    localparam int SCALED_W = DEG_W + 6;
    localparam int RECIP_W  = 23;
    localparam int RECIP_SH = 28;
    localparam int PROD_W   = SCALED_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP_45 = 23'd5965233;

    localparam logic [PHASE_W-1:0] FULL_LAST = 3'd3;
    localparam logic [PHASE_W-1:0] HALF_LAST = 3'd7;

    typedef struct packed {
        logic [DELAY_W-1:0] step_delay;
        logic               half_step;
    } cfg_t;

    typedef struct packed {
        logic              rejected;
        logic              done_res;
        logic              busy_res;
        logic [COIL_W-1:0] coils;
    } result_t;

    function automatic logic [COIL_W-1:0] pattern_of(input logic half,
                                                     input logic [PHASE_W-1:0] idx);
        logic [COIL_W-1:0] pat;
        if (half)
        begin
            case (idx)
                3'd0:    pat = 4'h1;
                3'd1:    pat = 4'h3;
                3'd2:    pat = 4'h2;
                3'd3:    pat = 4'h6;
                3'd4:    pat = 4'h4;
                3'd5:    pat = 4'hC;
                3'd6:    pat = 4'h8;
                default: pat = 4'h9;
            endcase
        end
        else
        begin
            case (idx[1:0])
                2'd0:    pat = 4'h3;
                2'd1:    pat = 4'h6;
                2'd2:    pat = 4'hC;
                default: pat = 4'h9;
            endcase
        end
        return pat;
    endfunction

endpackage

### rtl/stepper_phase_sequencer_unit.sv
// Top level of the stepper phase sequencer: ports, configuration and result buffer.
//
// Channel   Direction  Signals                         Content
// s_*       in         s_tvalid s_tready s_tdata s_tuser  tick or move command beat
// m_*       out        m_tvalid m_tready m_tdata         one result beat per input beat
// cfg_*     in         cfg_valid cfg_ready cfg_index cfg_data  register write
//
// Each input beat's result is registered on the same edge that accepts the beat.
// A two-entry result buffer lets a new beat be accepted while a result waits.
// The input is stalled only when both buffer entries are full.
// Reset clears the sequencer to idle with all coils off and step_delay of 2.
module stepper_phase_sequencer_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] degrees
    input  logic [0:0]  s_tuser,   // [0] func
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [3:0] coils, [4] busy_res, [5] done_res, [6] rejected
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [sps_pkg::IDX_W-1:0] cfg_index,
    input  logic [15:0] cfg_data
);

    sps_pkg::cfg_t    cfg_reg;
    sps_pkg::result_t core_res;
    sps_pkg::result_t head_reg, head_next;
    sps_pkg::result_t skid_reg, skid_next;
    logic [1:0]       count_reg, count_next;
    logic             push;
    logic             pop;

    assign cfg_ready = 1'b1;
    assign s_tready  = (count_reg != 2'd2);
    assign push      = s_tvalid && s_tready;
    assign pop       = m_tvalid && m_tready;
    assign m_tvalid  = (count_reg != 2'd0);
    assign m_tdata   = {1'b0, head_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.step_delay <= sps_pkg::STEP_DELAY_RST;
            cfg_reg.half_step  <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                sps_pkg::REG_STEP_DELAY: cfg_reg.step_delay <= cfg_data;
                sps_pkg::REG_HALF_STEP:  cfg_reg.half_step  <= cfg_data[0];
                default: ;
            endcase
        end
    end

    sps_core u_core
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (push),
        .func    (s_tuser[0]),
        .degrees (s_tdata),
        .cfg     (cfg_reg),
        .result  (core_res)
    );

    always_comb
    begin
        head_next  = head_reg;
        skid_next  = skid_reg;
        count_next = count_reg;
        if (push && pop)
        begin
            if (count_reg == 2'd1)
            begin
                head_next = core_res;
            end
            else
            begin
                head_next = skid_reg;
                skid_next = core_res;
            end
        end
        else if (pop)
        begin
            head_next  = skid_reg;
            count_next = count_reg - 2'd1;
        end
        else if (push)
        begin
            if (count_reg == 2'd0)
            begin
                head_next = core_res;
            end
            else
            begin
                skid_next = core_res;
            end
            count_next = count_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
        skid_reg <= skid_next;
    end

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("result buffer count out of range");

    a_stall_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid)
        else $error("input stalled with no result pending");

    a_reject_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && head_reg.rejected) |-> head_reg.busy_res)
        else $error("rejected result without busy");

    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && head_reg.done_res) |-> !head_reg.busy_res)
        else $error("done result still busy");
`endif

endmodule

### rtl/sps_core.sv
// Sequencer state and the single-pass update applied to each accepted beat.
module sps_core
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         accept,
    input  logic                         func,
    input  logic [sps_pkg::DEG_W-1:0]    degrees,
    input  sps_pkg::cfg_t                cfg,
    output sps_pkg::result_t             result
);

    logic [sps_pkg::COIL_W-1:0]  coil_reg,   coil_next;
    logic [sps_pkg::PHASE_W-1:0] phase_reg,  phase_next;
    logic [sps_pkg::DELAY_W-1:0] hold_reg,   hold_next;
    logic [sps_pkg::SEQ_W-1:0]   seqs_reg,   seqs_next;
    logic [sps_pkg::SEQ_W-1:0]   target_reg, target_next;
    logic                        moving_reg, moving_next;

    logic [sps_pkg::SCALED_W-1:0] scaled;
    logic [sps_pkg::PROD_W-1:0]   prod;
    logic [sps_pkg::SEQ_W-1:0]    target_cmd;
    logic [sps_pkg::DELAY_W-1:0]  delay;
    logic [sps_pkg::DELAY_W-1:0]  hold_inc;
    logic [sps_pkg::SEQ_W-1:0]    seqs_inc;
    logic [sps_pkg::PHASE_W-1:0]  last_phase;
    logic                         done_flag;
    logic                         rej_flag;

    assign scaled     = {degrees, 6'b0};
    assign prod       = sps_pkg::PROD_W'(scaled) * sps_pkg::PROD_W'(sps_pkg::RECIP_45);
    assign target_cmd = prod[sps_pkg::RECIP_SH +: sps_pkg::SEQ_W];
    assign delay      = (cfg.step_delay == '0) ? sps_pkg::DELAY_W'(1) : cfg.step_delay;
    assign hold_inc   = hold_reg + sps_pkg::DELAY_W'(1);
    assign seqs_inc   = seqs_reg + sps_pkg::SEQ_W'(1);
    assign last_phase = cfg.half_step ? sps_pkg::HALF_LAST : sps_pkg::FULL_LAST;

    always_comb
    begin
        coil_next   = coil_reg;
        phase_next  = phase_reg;
        hold_next   = hold_reg;
        seqs_next   = seqs_reg;
        target_next = target_reg;
        moving_next = moving_reg;
        done_flag   = 1'b0;
        rej_flag    = 1'b0;
        if (func)
        begin
            if (moving_reg)
            begin
                rej_flag = 1'b1;
            end
            else if (target_cmd == '0)
            begin
                done_flag = 1'b1;
            end
            else
            begin
                target_next = target_cmd;
                seqs_next   = '0;
                phase_next  = '0;
                hold_next   = '0;
                moving_next = 1'b1;
                coil_next   = sps_pkg::pattern_of(cfg.half_step, '0);
            end
        end
        else if (moving_reg)
        begin
            hold_next = hold_inc;
            if (hold_inc >= delay)
            begin
                hold_next = '0;
                if (phase_reg >= last_phase)
                begin
                    phase_next = '0;
                    seqs_next  = seqs_inc;
                    if (seqs_inc >= target_reg)
                    begin
                        moving_next = 1'b0;
                        done_flag   = 1'b1;
                    end
                end
                else
                begin
                    phase_next = phase_reg + sps_pkg::PHASE_W'(1);
                end
                if (moving_next)
                begin
                    coil_next = sps_pkg::pattern_of(cfg.half_step, phase_next);
                end
            end
        end
    end

    assign result.coils    = coil_next;
    assign result.busy_res = moving_next;
    assign result.done_res = done_flag;
    assign result.rejected = rej_flag;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coil_reg   <= '0;
            phase_reg  <= '0;
            hold_reg   <= '0;
            seqs_reg   <= '0;
            target_reg <= '0;
            moving_reg <= 1'b0;
        end
        else if (accept)
        begin
            coil_reg   <= coil_next;
            phase_reg  <= phase_next;
            hold_reg   <= hold_next;
            seqs_reg   <= seqs_next;
            target_reg <= target_next;
            moving_reg <= moving_next;
        end
    end

endmodule

### dv/tb_stepper_phase_sequencer_unit.sv
// Self-checking testbench for the stepper phase sequencer unit: directed table, random phases.
module tb_stepper_phase_sequencer_unit;

    typedef enum logic [1:0] {TRAFFIC_NONE, TRAFFIC_SRC, TRAFFIC_SNK, TRAFFIC_BOTH} traffic_t;
    typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

    localparam logic FUNC_TICK = 1'b0;
    localparam logic FUNC_MOVE = 1'b1;

    localparam logic [sps_pkg::COIL_W-1:0] FULL_WAVE [4] = '{4'h3, 4'h6, 4'hC, 4'h9};
    localparam logic [sps_pkg::COIL_W-1:0] HALF_WAVE [8] =
        '{4'h1, 4'h3, 4'h2, 4'h6, 4'h4, 4'hC, 4'h8, 4'h9};

    localparam int               STALL_LIMIT   = 2000;
    localparam int               LONG_HOLD     = 60;
    localparam sps_pkg::result_t NO_RES        = '0;

    typedef struct packed {
        row_kind_t                  kind;
        logic [sps_pkg::IDX_W-1:0]  reg_idx;
        logic                       func;
        logic [15:0]                value;
        logic                       has_exp;
        sps_pkg::result_t           exp;
    } stim_row_t;

    typedef struct packed {
        logic [sps_pkg::DELAY_W-1:0] delay;
        logic                        half;
        traffic_t                    mode;
        logic [15:0]                 items;
    } phase_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       s_tvalid = 1'b0;
    logic                       s_tready;
    logic [15:0]                s_tdata = '0;
    logic [0:0]                 s_tuser = '0;
    logic                       m_tvalid;
    logic                       m_tready = 1'b0;
    logic [7:0]                 m_tdata;
    logic                       cfg_valid = 1'b0;
    logic                       cfg_ready;
    logic [sps_pkg::IDX_W-1:0]  cfg_index = '0;
    logic [15:0]                cfg_data = '0;

    // Predictor state and configuration copy.
    logic [sps_pkg::DELAY_W-1:0] cfg_delay;
    logic                        cfg_half;
    logic [sps_pkg::COIL_W-1:0]  seq_coils;
    logic [sps_pkg::PHASE_W-1:0] seq_phase;
    logic [sps_pkg::DELAY_W-1:0] seq_hold;
    logic [sps_pkg::SEQ_W-1:0]   seq_count;
    logic [sps_pkg::SEQ_W-1:0]   seq_target;
    logic                        seq_moving;

    sps_pkg::result_t coil_results_q[$];
    traffic_t         traffic_mode = TRAFFIC_NONE;
    logic             long_hold_req = 1'b0;
    int               long_hold_cycles = 0;
    int               idle_cycles = 0;
    int               mismatch_count = 0;
    int               items_sent = 0;
    int               results_seen = 0;
    int               moves_finished = 0;
    int               moves_refused = 0;

    stepper_phase_sequencer_unit u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic sps_pkg::result_t mk_res(input logic [sps_pkg::COIL_W-1:0] coils,
                                                input logic busy, input logic done,
                                                input logic rej);
        sps_pkg::result_t r;
        r.coils    = coils;
        r.busy_res = busy;
        r.done_res = done;
        r.rejected = rej;
        return r;
    endfunction

    function automatic logic [sps_pkg::COIL_W-1:0] coil_drive(
        input logic [sps_pkg::PHASE_W-1:0] idx);
        return cfg_half ? HALF_WAVE[idx] : FULL_WAVE[idx[1:0]];
    endfunction

    function automatic sps_pkg::result_t step_sequencer(input logic func,
                                                        input logic [15:0] deg);
        sps_pkg::result_t            r;
        int unsigned                 seqs;
        logic [sps_pkg::DELAY_W-1:0] hold_limit;
        logic [sps_pkg::PHASE_W-1:0] last_phase;
        r = NO_RES;
        if (func == FUNC_MOVE)
        begin
            if (seq_moving)
                r.rejected = 1'b1;
            else
            begin
                seqs = (32'(deg) * 32'd64) / 32'd45;
                if (seqs == 0)
                    r.done_res = 1'b1;
                else
                begin
                    seq_target = seqs[sps_pkg::SEQ_W-1:0];
                    seq_count  = '0;
                    seq_phase  = '0;
                    seq_hold   = '0;
                    seq_moving = 1'b1;
                    seq_coils  = coil_drive('0);
                end
            end
        end
        else if (seq_moving)
        begin
            hold_limit = (cfg_delay == '0) ? 16'd1 : cfg_delay;
            seq_hold   = seq_hold + sps_pkg::DELAY_W'(1);
            if (seq_hold >= hold_limit)
            begin
                last_phase = cfg_half ? sps_pkg::HALF_LAST : sps_pkg::FULL_LAST;
                seq_hold   = '0;
                if (seq_phase >= last_phase)
                begin
                    seq_phase = '0;
                    seq_count = seq_count + sps_pkg::SEQ_W'(1);
                    if (seq_count >= seq_target)
                    begin
                        seq_moving = 1'b0;
                        r.done_res = 1'b1;
                    end
                end
                else
                    seq_phase = seq_phase + sps_pkg::PHASE_W'(1);
                if (seq_moving)
                    seq_coils = coil_drive(seq_phase);
            end
        end
        r.coils    = seq_coils;
        r.busy_res = seq_moving;
        return r;
    endfunction

    function automatic int src_idle_pct(input traffic_t mode);
        return (mode == TRAFFIC_SRC) ? 65 : (mode == TRAFFIC_BOTH) ? 25 : 0;
    endfunction

    function automatic int sink_stall_pct(input traffic_t mode);
        return (mode == TRAFFIC_SNK) ? 65 : (mode == TRAFFIC_BOTH) ? 25 : 0;
    endfunction

    task automatic send_item(input logic func, input logic [15:0] deg,
                             input logic use_exp, input sps_pkg::result_t exp);
        sps_pkg::result_t pred;
        while ($urandom_range(99) < src_idle_pct(traffic_mode))
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid   <= 1'b1;
        s_tuser[0] <= func;
        s_tdata    <= deg;
        do
            @(posedge clk);
        while (!s_tready);
        pred = step_sequencer(func, deg);
        coil_results_q.push_back(use_exp ? exp : pred);
        items_sent++;
        if (pred.done_res)
            moves_finished++;
        if (pred.rejected)
            moves_refused++;
        @(negedge clk);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        do
            @(negedge clk);
        while (coil_results_q.size() != 0);
    endtask

    task automatic write_reg(input logic [sps_pkg::IDX_W-1:0] idx, input logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == sps_pkg::REG_STEP_DELAY)
            cfg_delay = val;
        else
            cfg_half = val[0];
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    always @(negedge clk)
    begin
        if (long_hold_req)
        begin
            m_tready <= 1'b0;
            long_hold_cycles++;
            if (long_hold_cycles == LONG_HOLD)
            begin
                long_hold_cycles = 0;
                long_hold_req    = 1'b0;
            end
        end
        else
            m_tready <= ($urandom_range(99) >= sink_stall_pct(traffic_mode));
    end

    always @(posedge clk)
    begin
        sps_pkg::result_t want;
        sps_pkg::result_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = sps_pkg::result_t'(m_tdata[6:0]);
            results_seen++;
            if (coil_results_q.size() == 0)
            begin
                $display("%0t: result beat with nothing expected: %h", $time, got);
                mismatch_count++;
            end
            else
            begin
                want = coil_results_q.pop_front();
                if (got.coils !== want.coils || got.busy_res !== want.busy_res ||
                    got.done_res !== want.done_res || got.rejected !== want.rejected)
                begin
                    $display("%0t: expected c=%h b=%b d=%b r=%b, actual c=%h b=%b d=%b r=%b",
                             $time, want.coils, want.busy_res, want.done_res, want.rejected,
                             got.coils, got.busy_res, got.done_res, got.rejected);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no beat accepted for %0d cycles", $time, STALL_LIMIT);
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        stim_row_t   dir_table[$];
        phase_t      phases[$];
        logic        func;
        logic [15:0] deg;
        int          pick;

        cfg_delay  = sps_pkg::STEP_DELAY_RST;
        cfg_half   = 1'b0;
        seq_coils  = '0;
        seq_phase  = '0;
        seq_hold   = '0;
        seq_count  = '0;
        seq_target = '0;
        seq_moving = 1'b0;

        dir_table.push_back('{ROW_ITEM, sps_pkg::REG_STEP_DELAY, FUNC_TICK, 16'h0000, 1'b1,
                              mk_res(4'h0, 1'b0, 1'b0, 1'b0)});
        dir_table.push_back('{ROW_ITEM, sps_pkg::REG_STEP_DELAY, FUNC_TICK, 16'hFFFF, 1'b1,
                              mk_res(4'h0, 1'b0, 1'b0, 1'b0)});
        dir_table.push_back('{ROW_ITEM, sps_pkg::REG_STEP_DELAY, FUNC_MOVE, 16'h0000, 1'b1,
                              mk_res(4'h0, 1'b0, 1'b1, 1'b0)});
        dir_table.push_back('{ROW_ITEM, sps_pkg::REG_STEP_DELAY, FUNC_MOVE, 16'h0001, 1'b1,
                              mk_res(4'h3, 1'b1, 1'b0, 1'b0)});
        dir_table.push_back('{ROW_ITEM, sps_pkg::REG_STEP_DELAY, FUNC_MOVE, 16'hFFFF, 1'b1,
                              mk_res(4'h3, 1'b1, 1'b0, 1'b1)});
        dir_table.push_back('{ROW_ITEM, sps_pkg::REG_STEP_DELAY, FUNC_MOVE, 16'h0000, 1'b0,
                              NO_RES});
        for (int i = 0; i < 8; i++)
            dir_table.push_back('{ROW_ITEM, sps_pkg::REG_STEP_DELAY, FUNC_TICK,
                                  (i % 2) ? 16'hAAAA : 16'h5555, 1'b0, NO_RES});
        dir_table.push_back('{ROW_CFG, sps_pkg::REG_STEP_DELAY, FUNC_TICK, 16'h0000, 1'b0,
                              NO_RES});
        dir_table.push_back('{ROW_CFG, sps_pkg::REG_HALF_STEP, FUNC_TICK, 16'h0001, 1'b0,
                              NO_RES});
        dir_table.push_back('{ROW_ITEM, sps_pkg::REG_STEP_DELAY, FUNC_MOVE, 16'h0002, 1'b1,
                              mk_res(4'h1, 1'b1, 1'b0, 1'b0)});
        for (int i = 0; i < 5; i++)
            dir_table.push_back('{ROW_ITEM, sps_pkg::REG_STEP_DELAY, FUNC_TICK, 16'h0000,
                                  1'b0, NO_RES});
        // Switching to full step with the phase index past three exercises the wrap.
        dir_table.push_back('{ROW_CFG, sps_pkg::REG_HALF_STEP, FUNC_TICK, 16'h0000, 1'b0,
                              NO_RES});
        for (int i = 0; i < 6; i++)
            dir_table.push_back('{ROW_ITEM, sps_pkg::REG_STEP_DELAY, FUNC_TICK, 16'h0000,
                                  1'b0, NO_RES});

        phases.push_back('{16'd1,     1'b0, TRAFFIC_NONE, 16'd300});
        phases.push_back('{16'd3,     1'b1, TRAFFIC_SRC,  16'd300});
        phases.push_back('{16'd65535, 1'b1, TRAFFIC_SNK,  16'd80});
        phases.push_back('{16'd2,     1'b0, TRAFFIC_BOTH, 16'd300});
        phases.push_back('{16'd0,     1'b1, TRAFFIC_NONE, 16'd250});
        phases.push_back('{16'd1,     1'b1, TRAFFIC_SNK,  16'd300});
        phases.push_back('{16'd4,     1'b0, TRAFFIC_BOTH, 16'd300});

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        traffic_mode = TRAFFIC_BOTH;
        foreach (dir_table[i])
        begin
            if (dir_table[i].kind == ROW_CFG)
            begin
                drain_results();
                write_reg(dir_table[i].reg_idx, dir_table[i].value);
            end
            else
                send_item(dir_table[i].func, dir_table[i].value,
                          dir_table[i].has_exp, dir_table[i].exp);
        end

        foreach (phases[p])
        begin
            drain_results();
            write_reg(sps_pkg::REG_STEP_DELAY, phases[p].delay);
            write_reg(sps_pkg::REG_HALF_STEP, {15'd0, phases[p].half});
            traffic_mode = phases[p].mode;
            for (int i = 0; i < phases[p].items; i++)
            begin
                if (p == 0 && i == 100)
                    long_hold_req = 1'b1;
                if (p == 3 && i == 150)
                    drain_results();
                deg = 16'($urandom);
                if (seq_moving)
                    func = ($urandom_range(99) < 6) ? FUNC_MOVE : FUNC_TICK;
                else if ($urandom_range(99) < 35)
                begin
                    func = FUNC_MOVE;
                    pick = $urandom_range(99);
                    if (pick < 70)
                        deg = 16'($urandom_range(3));
                    else if (pick < 95)
                        deg = 16'($urandom_range(12, 4));
                    else
                        deg = 16'($urandom_range(60, 13));
                end
                else
                    func = FUNC_TICK;
                send_item(func, deg, 1'b0, NO_RES);
            end
        end

        // Run the last move out, then start the widest possible move from idle.
        while (seq_moving)
            send_item(FUNC_TICK, 16'($urandom), 1'b0, NO_RES);
        send_item(FUNC_MOVE, 16'hFFFF, 1'b1, mk_res(4'h3, 1'b1, 1'b0, 1'b0));
        send_item(FUNC_TICK, 16'h0000, 1'b0, NO_RES);
        drain_results();
        repeat (10) @(posedge clk);

        $display("Sent %0d beats over %0d phases, step delay 0 to 65535, full and half step.",
                 items_sent, phases.size());
        $display("Checked %0d results: %0d moves finished, %0d commands refused while busy.",
                 results_seen, moves_finished, moves_refused);
        if (mismatch_count == 0 && coil_results_q.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
